// File: hw/rtl/pswap_pkg.sv
// Shared types and constants for the pairwise swap local search block.
`default_nettype none
package pswap_pkg;

  localparam int unsigned FRAG_W      = 7;
  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned PASS_W      = 20;
  localparam int unsigned CFG_DATA_W  = 20;
  localparam int unsigned IN_WEIGHT_W = 16;
  localparam logic [PASS_W-1:0]  PASSES_AT_RESET = 20'd90000;
  localparam logic [COUNT_W-1:0] COUNT_AT_RESET  = 8'd128;

  typedef enum logic [1:0] {
    CMD_WR_WEIGHT = 2'd0,
    CMD_WR_ORDER  = 2'd1,
    CMD_RUN       = 2'd2,
    CMD_RD_ORDER  = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_FRAG_COUNT = 1'b0,
    REG_MAX_PASSES = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_READBACK = 1'b0,
    KIND_RUN_DONE = 1'b1
  } result_kind_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD, ST_PASS, ST_DONE,
    G_I0, G_I1, G_I2, G_I3,
    G_J0, G_J1, G_J2, G_J3, G_J4,
    S_WID, S_LO, S_HA, S_HB, S_PICK, S_FA, S_FB,
    A_CLR, A_RD, A_CAP, A_U1, A_U2, A_S1, A_S2, A_S3
  } state_t;

endpackage
`default_nettype wire

// File: hw/rtl/pswap_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module pswap_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/pairwise_swap_local_search_core.sv
// Pairwise swap local search: command decode, search sequencer and stores.
//
// Usage: load the weight matrix (cmd 0) and the fragment order (cmd 1), one word
// per cycle, then issue a run (cmd 2). Order entries are read back with cmd 3.
// Input and result channels use valid/ready; the configuration port is a plain
// write port (index 0 fragment count, index 1 pass limit), written while idle
// by the user; the block does not enforce this. Writes give no result word. A
// read-back reads the order memory when accepted and loads the entry into the
// output register from ST_RD. Each pass of a run scores every position pair
// (one read per cycle from the weight and order memories), sorts the improving
// candidates with a merge sort (n log n, one candidate read per element),
// walks the MAX_FRAGMENTS used marks to clear them, then applies each candidate
// swap in sorted order or skips its pair. The input is ready only while no
// command is in progress.
// Reset clears the control state and sets the fragment count to 128 and the
// pass limit to 90000; the memories hold no defined contents until written.
// When the receiver stalls, the finished result word waits in the output
// register; the block holds only when its next result word is ready first.
`default_nettype none
module pairwise_swap_local_search_core #(
  parameter int unsigned MAX_FRAGMENTS  = 128,
  parameter int unsigned MAX_CANDIDATES = 8192,
  parameter int unsigned WEIGHT_BITS    = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       in_cmd,
  input  wire logic [pswap_pkg::FRAG_W-1:0]     in_row,
  input  wire logic [pswap_pkg::FRAG_W-1:0]     in_col,
  input  wire logic signed [pswap_pkg::IN_WEIGHT_W-1:0] in_weight,
  input  wire logic [pswap_pkg::FRAG_W-1:0]     in_position,
  input  wire logic [pswap_pkg::FRAG_W-1:0]     in_fragment,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_result_kind,
  output logic [pswap_pkg::FRAG_W-1:0]          out_fragment_out,
  output logic [pswap_pkg::PASS_W-1:0]          out_passes_done,
  output logic                                  out_stopped_by_limit,
  input  wire logic                             cfg_we,
  input  wire logic                             cfg_index,
  input  wire logic [pswap_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pswap_pkg::*;

  localparam int unsigned FB  = $clog2(MAX_FRAGMENTS);
  localparam int unsigned PW  = $clog2(MAX_FRAGMENTS + 1) + 1;
  localparam int unsigned WAW = $clog2(MAX_FRAGMENTS * MAX_FRAGMENTS);
  localparam int unsigned CW  = $clog2(MAX_CANDIDATES);
  localparam int unsigned NW  = $clog2(MAX_CANDIDATES + 1) + 2;
  localparam int unsigned SW  = WEIGHT_BITS + 2;
  localparam int unsigned CE  = 2 * FB + SW;

  // Control and working registers.
  state_t                  state_r, state_nxt;
  logic [COUNT_W-1:0]      fc_r, fc_nxt;
  logic [PASS_W-1:0]       mp_r, mp_nxt;
  logic [PW-1:0]           k_r, k_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [FRAG_W-1:0]       oa_r, oa_nxt, ob_r, ob_nxt, oj_r, oj_nxt, ojn_r, ojn_nxt;
  logic [FRAG_W-1:0]       oi_r, oi_nxt;
  logic signed [WEIGHT_BITS-1:0] wab_r, wab_nxt, w1_r, w1_nxt, w2_r, w2_nxt;
  logic                    wz_r, wz_nxt;
  logic [NW-1:0]           cnt_r, cnt_nxt, width_r, width_nxt, lo_r, lo_nxt;
  logic [NW-1:0]           mid_r, mid_nxt, hi_r, hi_nxt, a_r, a_nxt, b_r, b_nxt;
  logic [NW-1:0]           kk_r, kk_nxt, ci_r, ci_nxt;
  logic [CE-1:0]           ha_r, ha_nxt, hb_r, hb_nxt;
  logic                    src_r, src_nxt;
  logic [PASS_W-1:0]       pass_r, pass_nxt;
  logic                    lim_r, lim_nxt;
  logic                    oob_r, oob_nxt;
  logic [FB-1:0]           pi_r, pi_nxt, pj_r, pj_nxt;
  logic [FB-1:0]           clr_r, clr_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_kind_r, out_kind_nxt;
  logic [FRAG_W-1:0]       out_frag_r, out_frag_nxt;
  logic [PASS_W-1:0]       out_pass_r, out_pass_nxt;
  logic                    out_lim_r, out_lim_nxt;

  // Memory ports.
  logic                    w_we, w_re;
  logic [WAW-1:0]          w_waddr, w_raddr;
  logic [WEIGHT_BITS-1:0]  w_wdata, w_rdata;
  logic                    o_we, o_re;
  logic [FB-1:0]           o_waddr, o_raddr;
  logic [FRAG_W-1:0]       o_wdata, o_rdata;
  logic                    c_we, c_wbank, c_re;
  logic [CW-1:0]           c_waddr, c_raddr;
  logic [CE-1:0]           c_wdata, c_rdata0, c_rdata1, c_rdata;
  logic                    u_we, u_re, u_wdata, u_rdata;
  logic [FB-1:0]           u_waddr, u_raddr;

  // Helpers.
  logic [FRAG_W-1:0]       wa, wb;
  logic signed [WEIGHT_BITS-1:0] wv;
  logic signed [SW-1:0]    d_c;
  logic [NW-1:0]           mid_c, hi_c;
  logic                    av, bv, take_b, accept;
  logic [FB-1:0]           cpi, cpj;

  pswap_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_FRAGMENTS * MAX_FRAGMENTS)) u_weight (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .re(w_re), .raddr(w_raddr), .rdata(w_rdata)
  );
  pswap_ram #(.WIDTH(FRAG_W), .DEPTH(MAX_FRAGMENTS)) u_order (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .re(o_re), .raddr(o_raddr), .rdata(o_rdata)
  );
  pswap_ram #(.WIDTH(CE), .DEPTH(MAX_CANDIDATES)) u_cand0 (
    .clk(clk), .we(c_we && !c_wbank), .waddr(c_waddr), .wdata(c_wdata),
    .re(c_re), .raddr(c_raddr), .rdata(c_rdata0)
  );
  pswap_ram #(.WIDTH(CE), .DEPTH(MAX_CANDIDATES)) u_cand1 (
    .clk(clk), .we(c_we && c_wbank), .waddr(c_waddr), .wdata(c_wdata),
    .re(c_re), .raddr(c_raddr), .rdata(c_rdata1)
  );
  pswap_ram #(.WIDTH(1), .DEPTH(MAX_FRAGMENTS)) u_used (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .re(u_re), .raddr(u_raddr), .rdata(u_rdata)
  );

  assign c_rdata  = src_r ? c_rdata1 : c_rdata0;
  assign wv       = wz_r ? '0 : $signed(w_rdata);
  assign d_c      = SW'(w1_r) + SW'(w2_r) - SW'(wab_r) - SW'(wv);
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign cpi      = c_rdata[CE-1:SW+FB];
  assign cpj      = c_rdata[SW+FB-1:SW];
  assign mid_c    = (lo_r + width_r < cnt_r) ? lo_r + width_r : cnt_r;
  assign hi_c     = (lo_r + (width_r << 1) < cnt_r) ? lo_r + (width_r << 1) : cnt_r;
  assign av       = a_r < mid_r;
  assign bv       = b_r < hi_r;
  assign take_b   = bv && (!av || ($signed(hb_r[SW-1:0]) > $signed(ha_r[SW-1:0])));

  assign w_raddr  = WAW'(32'(wa) * MAX_FRAGMENTS + 32'(wb));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fc_r        <= COUNT_AT_RESET;
      mp_r        <= PASSES_AT_RESET;
      out_valid_r <= 1'b0;
      pass_r      <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      fc_r        <= fc_nxt;
      mp_r        <= mp_nxt;
      out_valid_r <= out_valid_nxt;
      pass_r      <= pass_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;  i_r <= i_nxt;  j_r <= j_nxt;
    oa_r <= oa_nxt;  ob_r <= ob_nxt;  oj_r <= oj_nxt;  ojn_r <= ojn_nxt;  oi_r <= oi_nxt;
    wab_r <= wab_nxt;  w1_r <= w1_nxt;  w2_r <= w2_nxt;  wz_r <= wz_nxt;
    width_r <= width_nxt;  lo_r <= lo_nxt;  mid_r <= mid_nxt;  hi_r <= hi_nxt;
    a_r <= a_nxt;  b_r <= b_nxt;  kk_r <= kk_nxt;  ci_r <= ci_nxt;
    ha_r <= ha_nxt;  hb_r <= hb_nxt;  src_r <= src_nxt;
    lim_r <= lim_nxt;  oob_r <= oob_nxt;  pi_r <= pi_nxt;  pj_r <= pj_nxt;
    clr_r <= clr_nxt;
    out_kind_r <= out_kind_nxt;  out_frag_r <= out_frag_nxt;
    out_pass_r <= out_pass_nxt;  out_lim_r <= out_lim_nxt;
  end

  always_comb begin
    state_nxt = state_r;  fc_nxt = fc_r;  mp_nxt = mp_r;
    k_nxt = k_r;  i_nxt = i_r;  j_nxt = j_r;
    oa_nxt = oa_r;  ob_nxt = ob_r;  oj_nxt = oj_r;  ojn_nxt = ojn_r;  oi_nxt = oi_r;
    wab_nxt = wab_r;  w1_nxt = w1_r;  w2_nxt = w2_r;
    cnt_nxt = cnt_r;  width_nxt = width_r;  lo_nxt = lo_r;  mid_nxt = mid_r;
    hi_nxt = hi_r;  a_nxt = a_r;  b_nxt = b_r;  kk_nxt = kk_r;  ci_nxt = ci_r;
    ha_nxt = ha_r;  hb_nxt = hb_r;  src_nxt = src_r;
    pass_nxt = pass_r;  lim_nxt = lim_r;  oob_nxt = oob_r;
    pi_nxt = pi_r;  pj_nxt = pj_r;  clr_nxt = clr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt = out_kind_r;  out_frag_nxt = out_frag_r;
    out_pass_nxt = out_pass_r;  out_lim_nxt = out_lim_r;

    w_we = 1'b0;  w_re = 1'b0;  wa = '0;  wb = '0;
    w_waddr = WAW'(32'(in_row) * MAX_FRAGMENTS + 32'(in_col));
    w_wdata = WEIGHT_BITS'(in_weight);
    o_we = 1'b0;  o_re = 1'b0;  o_waddr = FB'(in_position);  o_raddr = FB'(in_position);
    o_wdata = in_fragment;
    c_we = 1'b0;  c_wbank = !src_r;  c_re = 1'b0;
    c_waddr = kk_r[CW-1:0];  c_raddr = a_r[CW-1:0];
    c_wdata = take_b ? hb_r : ha_r;
    u_we = 1'b0;  u_re = 1'b0;  u_waddr = clr_r;  u_raddr = cpi;  u_wdata = 1'b0;

    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAG_COUNT: fc_nxt = cfg_wdata[COUNT_W-1:0];
        REG_MAX_PASSES: mp_nxt = cfg_wdata[PASS_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(in_cmd))
            CMD_WR_WEIGHT: begin
              w_we = (32'(in_row) < MAX_FRAGMENTS) && (32'(in_col) < MAX_FRAGMENTS);
            end
            CMD_WR_ORDER: o_we = 32'(in_position) < MAX_FRAGMENTS;
            CMD_RD_ORDER: begin
              o_re      = 1'b1;
              oob_nxt   = !(32'(in_position) < MAX_FRAGMENTS);
              state_nxt = ST_RD;
            end
            CMD_RUN: begin
              k_nxt     = (32'(fc_r) > MAX_FRAGMENTS) ? PW'(MAX_FRAGMENTS) : PW'(fc_r);
              pass_nxt  = '0;
              lim_nxt   = 1'b0;
              state_nxt = ST_PASS;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_READBACK;
          out_frag_nxt  = oob_r ? '0 : o_rdata;
          out_pass_nxt  = '0;
          out_lim_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_RUN_DONE;
          out_frag_nxt  = '0;
          out_pass_nxt  = pass_r;
          out_lim_nxt   = lim_r;
          state_nxt     = ST_IDLE;
        end
      end
      ST_PASS: begin
        if (pass_r >= mp_r) begin
          lim_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          i_nxt     = PW'(1);
          cnt_nxt   = '0;
          state_nxt = G_I0;
        end
      end
      // Gather: the outer position's neighbors and their weight are held per i.
      G_I0: begin
        if (i_r + PW'(1) >= k_r) begin
          if (cnt_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            width_nxt = NW'(1);
            src_nxt   = 1'b0;
            state_nxt = S_WID;
          end
        end else begin
          o_re      = 1'b1;
          o_raddr   = FB'(i_r - PW'(1));
          state_nxt = G_I1;
        end
      end
      G_I1: begin
        oa_nxt    = o_rdata;
        o_re      = 1'b1;
        o_raddr   = FB'(i_r);
        state_nxt = G_I2;
      end
      G_I2: begin
        ob_nxt    = o_rdata;
        w_re      = 1'b1;
        wa        = oa_r;
        wb        = o_rdata;
        state_nxt = G_I3;
      end
      G_I3: begin
        wab_nxt = wv;
        j_nxt   = i_r + PW'(1);
        if (i_r + PW'(2) >= k_r) begin
          i_nxt     = i_r + PW'(1);
          state_nxt = G_I0;
        end else begin
          o_re      = 1'b1;
          o_raddr   = FB'(i_r + PW'(1));
          state_nxt = G_J0;
        end
      end
      G_J0: begin
        oj_nxt    = o_rdata;
        o_re      = 1'b1;
        o_raddr   = FB'(j_r + PW'(1));
        state_nxt = G_J1;
      end
      G_J1: begin
        ojn_nxt   = o_rdata;
        w_re      = 1'b1;
        wa        = oa_r;
        wb        = oj_r;
        state_nxt = G_J2;
      end
      G_J2: begin
        w1_nxt    = wv;
        w_re      = 1'b1;
        wa        = ob_r;
        wb        = ojn_r;
        state_nxt = G_J3;
      end
      G_J3: begin
        w2_nxt    = wv;
        w_re      = 1'b1;
        wa        = oj_r;
        wb        = ojn_r;
        state_nxt = G_J4;
      end
      G_J4: begin
        if (!d_c[SW-1] && (d_c != '0) && (32'(cnt_r) < MAX_CANDIDATES)) begin
          c_we    = 1'b1;
          c_wbank = 1'b0;
          c_waddr = cnt_r[CW-1:0];
          c_wdata = {FB'(i_r), FB'(j_r), d_c};
          cnt_nxt = cnt_r + NW'(1);
        end
        if (j_r + PW'(2) < k_r) begin
          j_nxt     = j_r + PW'(1);
          oj_nxt    = ojn_r;
          o_re      = 1'b1;
          o_raddr   = FB'(j_r + PW'(2));
          state_nxt = G_J1;
        end else begin
          i_nxt     = i_r + PW'(1);
          state_nxt = G_I0;
        end
      end
      // Bottom-up merge sort, ping-ponging between the two candidate banks.
      S_WID: begin
        if (width_r >= cnt_r) begin
          clr_nxt   = '0;
          state_nxt = A_CLR;
        end else begin
          lo_nxt    = '0;
          state_nxt = S_LO;
        end
      end
      S_LO: begin
        if (lo_r >= cnt_r) begin
          width_nxt = width_r << 1;
          src_nxt   = !src_r;
          state_nxt = S_WID;
        end else begin
          mid_nxt   = mid_c;
          hi_nxt    = hi_c;
          a_nxt     = lo_r;
          b_nxt     = mid_c;
          kk_nxt    = lo_r;
          c_re      = 1'b1;
          c_raddr   = lo_r[CW-1:0];
          state_nxt = S_HA;
        end
      end
      S_HA: begin
        ha_nxt = c_rdata;
        if (mid_r < hi_r) begin
          c_re      = 1'b1;
          c_raddr   = mid_r[CW-1:0];
          state_nxt = S_HB;
        end else begin
          state_nxt = S_PICK;
        end
      end
      S_HB: begin
        hb_nxt    = c_rdata;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        if (!av && !bv) begin
          lo_nxt    = lo_r + (width_r << 1);
          state_nxt = S_LO;
        end else begin
          c_we   = 1'b1;
          kk_nxt = kk_r + NW'(1);
          if (take_b) begin
            b_nxt = b_r + NW'(1);
            if (b_r + NW'(1) < hi_r) begin
              c_re      = 1'b1;
              c_raddr   = CW'(b_r + NW'(1));
              state_nxt = S_FB;
            end
          end else begin
            a_nxt = a_r + NW'(1);
            if (a_r + NW'(1) < mid_r) begin
              c_re      = 1'b1;
              c_raddr   = CW'(a_r + NW'(1));
              state_nxt = S_FA;
            end
          end
        end
      end
      S_FA: begin
        ha_nxt    = c_rdata;
        state_nxt = S_PICK;
      end
      S_FB: begin
        hb_nxt    = c_rdata;
        state_nxt = S_PICK;
      end
      // The used marks are cleared one entry per cycle before the moves are applied.
      A_CLR: begin
        u_we    = 1'b1;
        u_waddr = clr_r;
        u_wdata = 1'b0;
        if (32'(clr_r) == MAX_FRAGMENTS - 1) begin
          ci_nxt    = '0;
          state_nxt = A_RD;
        end else begin
          clr_nxt = clr_r + FB'(1);
        end
      end
      // Greedy application in sorted order; a used position blocks a pair.
      A_RD: begin
        if (ci_r >= cnt_r) begin
          pass_nxt  = pass_r + PASS_W'(1);
          state_nxt = ST_PASS;
        end else begin
          c_re      = 1'b1;
          c_raddr   = ci_r[CW-1:0];
          state_nxt = A_CAP;
        end
      end
      A_CAP: begin
        pi_nxt    = cpi;
        pj_nxt    = cpj;
        ci_nxt    = ci_r + NW'(1);
        u_re      = 1'b1;
        u_raddr   = cpi;
        state_nxt = A_U1;
      end
      A_U1: begin
        if (u_rdata) begin
          state_nxt = A_RD;
        end else begin
          u_re      = 1'b1;
          u_raddr   = pj_r;
          state_nxt = A_U2;
        end
      end
      A_U2: begin
        if (u_rdata) begin
          state_nxt = A_RD;
        end else begin
          o_re      = 1'b1;
          o_raddr   = pi_r;
          state_nxt = A_S1;
        end
      end
      A_S1: begin
        oi_nxt    = o_rdata;
        o_re      = 1'b1;
        o_raddr   = pj_r;
        state_nxt = A_S2;
      end
      A_S2: begin
        o_we      = 1'b1;
        o_waddr   = pi_r;
        o_wdata   = o_rdata;
        u_we      = 1'b1;
        u_waddr   = pi_r;
        u_wdata   = 1'b1;
        state_nxt = A_S3;
      end
      A_S3: begin
        o_we      = 1'b1;
        o_waddr   = pj_r;
        o_wdata   = oi_r;
        u_we      = 1'b1;
        u_waddr   = pj_r;
        u_wdata   = 1'b1;
        state_nxt = A_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase

    wz_nxt = w_re ? ((32'(wa) >= MAX_FRAGMENTS) || (32'(wb) >= MAX_FRAGMENTS)) : wz_r;
  end

  assign out_valid            = out_valid_r;
  assign out_result_kind      = out_kind_r;
  assign out_fragment_out     = out_frag_r;
  assign out_passes_done      = out_pass_r;
  assign out_stopped_by_limit = out_lim_r;

`ifndef SYNTHESIS
  a_cand_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == G_J4 && c_we) |-> (32'(cnt_r) < MAX_CANDIDATES))
    else $error("candidate written past the store");
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == G_J4) |-> (i_r < j_r) && (j_r + PW'(1) < k_r))
    else $error("scored pair out of order or out of range");
  a_merge_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PICK) |-> (kk_r + mid_r == a_r + b_r))
    else $error("merge output index lost track of its inputs");
  a_swap_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == A_S2) |-> (pi_r < pj_r) && (PW'(pj_r) + PW'(1) < k_r))
    else $error("swap applied to a pair out of order or out of range");
`endif

endmodule
`default_nettype wire

// File: tb/sv/pairwise_swap_local_search_core_tb.sv
// Testbench for the pairwise swap local search core: directed and random words, scored against a predictor.
`default_nettype none
module pairwise_swap_local_search_core_tb;
  import pswap_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NFRAG     = 128;
  localparam int unsigned NCAND     = 8192;
  localparam int unsigned POOL_N    = 8;
  localparam int unsigned STALL_MAX = 4000000;

  typedef struct packed {
    logic              kind;
    logic [FRAG_W-1:0] frag;
    logic [PASS_W-1:0] passes;
    logic              by_limit;
  } result_word_t;

  class swap_search_scoreboard;
    shortint            wmat [NFRAG][NFRAG];
    logic [FRAG_W-1:0]  order [NFRAG];
    int unsigned        frag_count;
    int unsigned        pass_limit;
    int unsigned        cand_i [NCAND];
    int unsigned        cand_j [NCAND];
    longint             cand_s [NCAND];
    int unsigned        cand_n;
    result_word_t       expected [$];
    int                 errors;

    function new();
      frag_count = COUNT_AT_RESET;
      pass_limit = PASSES_AT_RESET;
      errors = 0;
    endfunction

    function void report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endfunction

    function void note_config(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
      if (idx == REG_FRAG_COUNT) frag_count = v[COUNT_W-1:0];
      else pass_limit = v;
    endfunction

    function longint w(logic [FRAG_W-1:0] a, logic [FRAG_W-1:0] b);
      return longint'(wmat[a][b]);
    endfunction

    // Scores every pair, keeps improving ones and sorts them stably, best first.
    function void score_pairs(int unsigned k);
      int unsigned i, j, a, b, xi, xj;
      longint d, xs;
      cand_n = 0;
      for (i = 1; i + 1 < k; i++)
        for (j = i + 1; j + 1 < k; j++) begin
          d = w(order[i-1], order[j]) + w(order[i], order[j+1])
            - w(order[i-1], order[i]) - w(order[j], order[j+1]);
          if (d > 0 && cand_n < NCAND) begin
            cand_i[cand_n] = i; cand_j[cand_n] = j; cand_s[cand_n] = d;
            cand_n++;
          end
        end
      for (a = 1; a < cand_n; a++) begin
        xi = cand_i[a]; xj = cand_j[a]; xs = cand_s[a];
        b = a;
        while (b > 0 && cand_s[b-1] < xs) begin
          cand_i[b] = cand_i[b-1]; cand_j[b] = cand_j[b-1]; cand_s[b] = cand_s[b-1];
          b--;
        end
        cand_i[b] = xi; cand_j[b] = xj; cand_s[b] = xs;
      end
    endfunction

    function result_word_t run_search();
      result_word_t r;
      bit used [NFRAG];
      int unsigned k, c;
      logic [FRAG_W-1:0] t;
      k = (frag_count > NFRAG) ? NFRAG : frag_count;
      r = '0;
      r.kind = KIND_RUN_DONE;
      forever begin
        if (r.passes >= pass_limit) begin
          r.by_limit = 1'b1;
          break;
        end
        score_pairs(k);
        if (cand_n == 0) break;
        foreach (used[p]) used[p] = 1'b0;
        for (c = 0; c < cand_n; c++)
          if (!used[cand_i[c]] && !used[cand_j[c]]) begin
            used[cand_i[c]] = 1'b1; used[cand_j[c]] = 1'b1;
            t = order[cand_i[c]];
            order[cand_i[c]] = order[cand_j[c]];
            order[cand_j[c]] = t;
          end
        r.passes++;
      end
      return r;
    endfunction

    function void note_word(cmd_t cmd, logic [FRAG_W-1:0] row, logic [FRAG_W-1:0] col,
                            logic signed [IN_WEIGHT_W-1:0] wt, logic [FRAG_W-1:0] pos,
                            logic [FRAG_W-1:0] frag);
      result_word_t r;
      case (cmd)
        CMD_WR_WEIGHT: wmat[row][col] = wt;
        CMD_WR_ORDER:  order[pos] = frag;
        CMD_RD_ORDER: begin
          r = '0;
          r.kind = KIND_READBACK;
          r.frag = order[pos];
          expected.insert(expected.size(), r);
        end
        default: expected.insert(expected.size(), run_search());
      endcase
    endfunction

    function void check_word(result_word_t got);
      result_word_t exp_w;
      if (expected.size() == 0) begin
        report($sformatf("unexpected result word %h", got));
        return;
      end
      exp_w = expected.pop_front();
      if (got.kind !== exp_w.kind)
        report($sformatf("result_kind %b, expected %b", got.kind, exp_w.kind));
      if (got.frag !== exp_w.frag)
        report($sformatf("fragment_out %0d, expected %0d", got.frag, exp_w.frag));
      if (got.passes !== exp_w.passes)
        report($sformatf("passes_done %0d, expected %0d", got.passes, exp_w.passes));
      if (got.by_limit !== exp_w.by_limit)
        report($sformatf("stopped_by_limit %b, expected %b", got.by_limit, exp_w.by_limit));
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] in_cmd;
  logic [FRAG_W-1:0] in_row, in_col, in_position, in_fragment;
  logic signed [IN_WEIGHT_W-1:0] in_weight;
  logic out_result_kind, out_stopped_by_limit;
  logic [FRAG_W-1:0] out_fragment_out;
  logic [PASS_W-1:0] out_passes_done;
  logic cfg_we, cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  swap_search_scoreboard sb;
  logic [FRAG_W-1:0] pool [POOL_N];
  int idle_mode;      // 0: light sender gaps, heavy receiver stalls; 1: reversed; 2: none
  bit hold_off_req;

  pairwise_swap_local_search_core u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_row, .in_col, .in_weight,
    .in_position, .in_fragment, .out_valid, .out_ready, .out_result_kind,
    .out_fragment_out, .out_passes_done, .out_stopped_by_limit,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Idle cycles come before the word is offered, so valid never drops while it waits.
  task automatic send_word(cmd_t cmd, logic [FRAG_W-1:0] row, logic [FRAG_W-1:0] col,
                           logic signed [IN_WEIGHT_W-1:0] wt, logic [FRAG_W-1:0] pos,
                           logic [FRAG_W-1:0] frag);
    int gap_pct;
    gap_pct = (idle_mode == 0) ? 22 : (idle_mode == 1) ? 59 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd; in_row <= row; in_col <= col;
    in_weight <= wt; in_position <= pos; in_fragment <= frag;
    do @(posedge clk); while (!in_ready);
    sb.note_word(cmd, row, col, wt, pos, frag);
  endtask

  // Drains all expected words; writes give no result, so allow a few more cycles.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected.size() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_config(logic [COUNT_W-1:0] k, logic [PASS_W-1:0] lim);
    settle();
    cfg_we <= 1'b1; cfg_index <= REG_FRAG_COUNT; cfg_wdata <= CFG_DATA_W'(k);
    @(posedge clk);
    sb.note_config(REG_FRAG_COUNT, CFG_DATA_W'(k));
    cfg_index <= REG_MAX_PASSES; cfg_wdata <= lim;
    @(posedge clk);
    sb.note_config(REG_MAX_PASSES, lim);
    cfg_we <= 1'b0;
  endtask

  task automatic random_word();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40)
      send_word(CMD_WR_WEIGHT, pool[$urandom_range(POOL_N-1)], pool[$urandom_range(POOL_N-1)],
                IN_WEIGHT_W'($urandom), '0, '0);
    else if (sel < 65)
      send_word(CMD_WR_ORDER, FRAG_W'($urandom), FRAG_W'($urandom), '0,
                FRAG_W'($urandom), pool[$urandom_range(POOL_N-1)]);
    else if (sel < 94)
      send_word(CMD_RD_ORDER, '0, '0, '0, FRAG_W'($urandom), '0);
    else
      send_word(CMD_RUN, FRAG_W'($urandom), FRAG_W'($urandom), IN_WEIGHT_W'($urandom),
                FRAG_W'($urandom), FRAG_W'($urandom));
  endtask

  // Receiver: random stalls per idle mode, plus one long hold-off.
  initial begin
    int stall_pct;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_word({out_result_kind, out_fragment_out, out_passes_done,
                       out_stopped_by_limit});
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      stall_pct = (idle_mode == 0) ? 59 : (idle_mode == 1) ? 22 : 0;
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: cycles with no word moving on either channel.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_MAX) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int unsigned p, q, n;
    logic [COUNT_W-1:0] k;
    sb = new();
    idle_mode = 0;
    hold_off_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0; in_cmd = '0; in_row = '0; in_col = '0; in_weight = '0;
    in_position = '0; in_fragment = '0;
    cfg_we = 1'b0; cfg_index = 1'b0; cfg_wdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fragment pool with both extremes; every weight among it and every order slot is
    // written up front, so no run or read ever touches an unwritten entry.
    pool[0] = 7'd0;
    pool[1] = 7'd127;
    for (p = 2; p < POOL_N; p++) pool[p] = FRAG_W'(p * 17 + $urandom_range(16));
    for (p = 0; p < POOL_N; p++)
      for (q = 0; q < POOL_N; q++)
        send_word(CMD_WR_WEIGHT, pool[p], pool[q],
                  (p == q) ? -16'sd32768 : (p + 1 == q) ? 16'sd32767
                                                        : IN_WEIGHT_W'($urandom), '0, '0);
    for (p = 0; p < NFRAG; p++)
      send_word(CMD_WR_ORDER, '0, '0, '0, FRAG_W'(p), pool[$urandom_range(POOL_N-1)]);
    send_word(CMD_RD_ORDER, '0, '0, '0, 7'd0, '0);
    send_word(CMD_RD_ORDER, '0, '0, '0, 7'd127, '0);

    // Directed runs: no pair, zero limit, huge limit, and a count above the store size.
    set_config(8'd2, 20'd5);       send_word(CMD_RUN, '0, '0, '0, '0, '0);
    set_config(8'd3, 20'd5);       send_word(CMD_RUN, '0, '0, '0, '0, '0);
    set_config(8'd6, 20'd0);       send_word(CMD_RUN, '0, '0, '0, '0, '0);
    set_config(8'd4, 20'hFFFFF);   send_word(CMD_RUN, '0, '0, '0, '0, '0);
    send_word(CMD_RD_ORDER, '0, '0, '0, 7'd1, '0);
    send_word(CMD_RD_ORDER, '0, '0, '0, 7'd2, '0);
    set_config(8'd255, 20'd2);     send_word(CMD_RUN, '0, '0, '0, '0, '0);
    set_config(8'd128, 20'd1);     send_word(CMD_RUN, '0, '0, '0, '0, '0);
    set_config(8'd10, 20'd1);      send_word(CMD_RUN, '0, '0, '0, '0, '0);

    n = 0;
    while (n < 1400) begin
      idle_mode = (n < 467) ? 0 : (n < 933) ? 1 : 2;
      k = ($urandom_range(9) == 0) ? COUNT_W'($urandom_range(3)) : COUNT_W'($urandom_range(4, 12));
      if (k == 4 && $urandom_range(1)) set_config(k, 20'hFFFFF);
      else set_config(k, PASS_W'($urandom_range(8)));
      for (p = 0; p < 100; p++) begin
        if (n + p == 300) hold_off_req = 1'b1;
        random_word();
      end
      n += 100;
    end

    settle();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (sb.expected.size() > 0)
        sb.report($sformatf("%0d expected words never arrived", sb.expected.size()));
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
